/* hdl/binary_min_heap_queue_top_defines.svh */
// Assertion macros shared by the heap queue checker.
`ifndef BINARY_MIN_HEAP_QUEUE_TOP_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define HMQ_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heap queue check failed");

// Next-cycle implication, sampled on clk and switched off during reset.
`define HMQ_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heap queue check failed");

`endif

/* hdl/hmq_pkg.sv */
// Shared types and constants of the binary min-heap queue.
`timescale 1ns / 1ps

package hmq_pkg;

    // Width of a heap level number; covers the deepest supported heap.
    localparam int LVL_W = 4;

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    // Read and write requests broadcast along the row of level cells.
    typedef struct packed {
        logic             rd_en;
        logic [LVL_W-1:0] rd_level;
        logic             wr_en;
        logic [LVL_W-1:0] wr_level;
    } cell_ctl_t;

endpackage

/* hdl/hmq_ram.sv */
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module hmq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/hmq_cell.sv */
// One heap level: its key storage and its stage of the read-data chain.
`timescale 1ns / 1ps

module hmq_cell #(
    parameter int LEVEL     = 0,
    parameter int KEY_WIDTH = 32,
    parameter int OFF_W     = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hmq_pkg::cell_ctl_t   ctl,
    input  logic [OFF_W-1:0]     rd_off,
    input  logic [OFF_W-1:0]     wr_off,
    input  logic [KEY_WIDTH-1:0] wdata,
    input  logic [KEY_WIDTH-1:0] chain_in,
    output logic [KEY_WIDTH-1:0] chain_out
);

    // The root level keeps a two-entry store so that it has an address bit.
    localparam int AW    = (LEVEL > 0) ? LEVEL : 1;
    localparam int DEPTH = 2 ** AW;

    logic             rd_sel;
    logic             wr_sel;
    logic [AW-1:0]    addr;
    logic [KEY_WIDTH-1:0] rdata;
    logic             sel_reg;

    assign rd_sel = ctl.rd_en && (ctl.rd_level == hmq_pkg::LVL_W'(LEVEL));
    assign wr_sel = ctl.wr_en && (ctl.wr_level == hmq_pkg::LVL_W'(LEVEL));
    assign addr   = wr_sel ? wr_off[AW-1:0] : rd_off[AW-1:0];

    hmq_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .wr_en (wr_sel),
        .rd_en (rd_sel),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    // Remember which level answered the last read so that its data wins the chain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= 1'b0;
        end
        else
        begin
            sel_reg <= rd_sel;
        end
    end

    assign chain_out = sel_reg ? rdata : chain_in;

endmodule

/* hdl/binary_min_heap_queue_top.sv */
// Top level of the binary min-heap priority queue.
`timescale 1ns / 1ps
//
// The queue keeps up to CAPACITY unsigned keys as a binary min-heap. Each input
// transaction on the s_ side is one operation: tuser bit 0 clear inserts the key in
// tdata, tuser bit 0 set extracts the minimum. Every operation produces exactly one
// result transaction on the m_ side with a status, the extracted key, the current
// minimum with its valid flag and the number of stored keys.
// The heap is held by a row of level cells, one per tree level, each with its own
// single-port RAM. An insert walks the path from the root to the new slot and moves
// one level per cycle. An extract reads the last key and then sifts it down level by
// level through a check, a left-child read and a right-child read, because each level
// reads two children through one registered read port.
// Full, empty and single-key cases go straight to the result state.
// One operation is worked on at a time; the controller returns to idle as the result
// is registered, and s_tready is high whenever the controller is idle, even while an
// earlier result still waits in the output register.
// If the receiver stalls, the finished result is held until the output register is
// free, and no further operation is accepted until then.
// Reset clears the entry count and the control state; the key storage needs no
// clearing, since only slots up to the count are ever read.

module binary_min_heap_queue_top #(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] key_in
    input  logic [0:0]  s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [31:0] key_out, [63:32] top_key, [70:64] entry_count
    output logic [2:0]  m_tuser    // [1:0] status, [2] top_valid
);

    localparam int LVL_W = hmq_pkg::LVL_W;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int NLEV  = CNT_W;
    localparam int OFF_W = NLEV - 1;
    localparam int IDX_W = CNT_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS,
        ST_LAST,
        ST_DCHK,
        ST_DLEFT,
        ST_DRIGHT,
        ST_FIN
    } state_t;

    // Level of a one-based heap position: index of its highest set bit.
    function automatic logic [LVL_W-1:0] floor_log2(input logic [CNT_W-1:0] v);
        logic [LVL_W-1:0] r;
        r = '0;
        for (int i = 0; i < CNT_W; i++)
        begin
            if (v[i])
            begin
                r = LVL_W'(i);
            end
        end
        return r;
    endfunction

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [KEY_WIDTH-1:0] root_reg, root_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [KEY_WIDTH-1:0] left_reg, left_next;
    logic [KEY_WIDTH-1:0] taken_reg, taken_next;
    logic [CNT_W-1:0]    node_reg, node_next;
    logic [LVL_W-1:0]    lvl_reg, lvl_next;
    logic [LVL_W-1:0]    top_lvl_reg, top_lvl_next;
    logic                right_ok_reg, right_ok_next;
    hmq_pkg::status_t    status_reg, status_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [71:0]         m_tdata_reg, m_tdata_next;
    logic [2:0]          m_tuser_reg, m_tuser_next;

    hmq_pkg::cell_ctl_t  ctl;
    logic [OFF_W-1:0]    rd_off;
    logic [OFF_W-1:0]    wr_off;
    logic [KEY_WIDTH-1:0] wdata;
    logic [KEY_WIDTH-1:0] chain [NLEV+1];
    logic [KEY_WIDTH-1:0] rdata;

    logic                accept;
    logic [KEY_WIDTH-1:0] key_in_w;
    logic [CNT_W-1:0]    new_n;
    logic [LVL_W-1:0]    new_lvl;
    logic [LVL_W-1:0]    last_lvl;
    logic [OFF_W-1:0]    mask_last;
    logic [LVL_W-1:0]    lvl_inc;
    logic [LVL_W-1:0]    ins_shift;
    logic [CNT_W-1:0]    anc_cur;
    logic [CNT_W-1:0]    anc_nxt;
    logic [OFF_W-1:0]    mask_cur;
    logic [OFF_W-1:0]    mask_nxt;
    logic [IDX_W-1:0]    child_left;
    logic [IDX_W-1:0]    child_right;
    logic [IDX_W-1:0]    cnt_wide;
    logic                pick_right;
    logic [KEY_WIDTH-1:0] pick_key;
    logic                out_free;

    // Row of level cells; read data ripples along the chain from the selected level.
    assign chain[0] = '0;

    for (genvar g = 0; g < NLEV; g++)
    begin : g_level
        hmq_cell #(
            .LEVEL     (g),
            .KEY_WIDTH (KEY_WIDTH),
            .OFF_W     (OFF_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .rd_off    (rd_off),
            .wr_off    (wr_off),
            .wdata     (wdata),
            .chain_in  (chain[g]),
            .chain_out (chain[g+1])
        );
    end

    assign rdata = chain[NLEV];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign key_in_w = KEY_WIDTH'(s_tdata);
    assign out_free = !m_tvalid_reg || m_tready;

    assign new_n     = cnt_reg + CNT_W'(1);
    assign new_lvl   = floor_log2(new_n);
    assign last_lvl  = floor_log2(cnt_reg);
    assign mask_last = (OFF_W'(1) << last_lvl) - OFF_W'(1);

    assign lvl_inc   = lvl_reg + LVL_W'(1);
    assign ins_shift = top_lvl_reg - lvl_reg;
    assign anc_cur   = node_reg >> ins_shift;
    assign anc_nxt   = node_reg >> (ins_shift - LVL_W'(1));
    assign mask_cur  = (OFF_W'(1) << lvl_reg) - OFF_W'(1);
    assign mask_nxt  = (OFF_W'(1) << lvl_inc) - OFF_W'(1);

    assign child_left  = {node_reg, 1'b0};
    assign child_right = child_left + IDX_W'(1);
    assign cnt_wide    = IDX_W'(cnt_reg);
    assign pick_right  = right_ok_reg && (rdata < left_reg);
    assign pick_key    = pick_right ? rdata : left_reg;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        key_next      = key_reg;
        left_next     = left_reg;
        taken_next    = taken_reg;
        node_next     = node_reg;
        lvl_next      = lvl_reg;
        top_lvl_next  = top_lvl_reg;
        right_ok_next = right_ok_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        ctl    = '0;
        rd_off = '0;
        wr_off = '0;
        wdata  = key_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    status_next = hmq_pkg::STAT_OK;
                    taken_next  = '0;
                    if (s_tuser[0] == hmq_pkg::OP_INSERT)
                    begin
                        if (cnt_reg == CNT_W'(CAPACITY))
                        begin
                            status_next = hmq_pkg::STAT_FULL;
                            state_next  = ST_FIN;
                        end
                        else
                        begin
                            cnt_next     = new_n;
                            node_next    = new_n;
                            top_lvl_next = new_lvl;
                            lvl_next     = '0;
                            key_next     = key_in_w;
                            // The root is on every path; fetch it unless it is the new slot.
                            ctl.rd_en    = (new_lvl != '0);
                            state_next   = ST_INS;
                        end
                    end
                    else
                    begin
                        if (cnt_reg == '0)
                        begin
                            status_next = hmq_pkg::STAT_EMPTY;
                            state_next  = ST_FIN;
                        end
                        else
                        begin
                            taken_next = root_reg;
                            cnt_next   = cnt_reg - CNT_W'(1);
                            if (cnt_reg == CNT_W'(1))
                            begin
                                state_next = ST_FIN;
                            end
                            else
                            begin
                                // Fetch the last key, which refills the root.
                                ctl.rd_en    = 1'b1;
                                ctl.rd_level = last_lvl;
                                rd_off       = cnt_reg[OFF_W-1:0] & mask_last;
                                state_next   = ST_LAST;
                            end
                        end
                    end
                end
            end

            ST_INS:
            begin
                ctl.wr_level = lvl_reg;
                wr_off       = anc_cur[OFF_W-1:0] & mask_cur;
                if (lvl_reg == top_lvl_reg)
                begin
                    ctl.wr_en  = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    // A smaller carried key takes this slot and pushes the old one down.
                    if (key_reg < rdata)
                    begin
                        ctl.wr_en = 1'b1;
                        key_next  = rdata;
                    end
                    lvl_next = lvl_inc;
                    if (lvl_inc != top_lvl_reg)
                    begin
                        ctl.rd_en    = 1'b1;
                        ctl.rd_level = lvl_inc;
                        rd_off       = anc_nxt[OFF_W-1:0] & mask_nxt;
                    end
                end
            end

            ST_LAST:
            begin
                key_next   = rdata;
                node_next  = CNT_W'(1);
                lvl_next   = '0;
                state_next = ST_DCHK;
            end

            ST_DCHK:
            begin
                if (child_left > cnt_wide)
                begin
                    ctl.wr_en    = 1'b1;
                    ctl.wr_level = lvl_reg;
                    wr_off       = node_reg[OFF_W-1:0] & mask_cur;
                    state_next   = ST_FIN;
                end
                else
                begin
                    ctl.rd_en     = 1'b1;
                    ctl.rd_level  = lvl_inc;
                    rd_off        = child_left[OFF_W-1:0] & mask_nxt;
                    right_ok_next = (child_left < cnt_wide);
                    state_next    = ST_DLEFT;
                end
            end

            ST_DLEFT:
            begin
                left_next    = rdata;
                ctl.rd_en    = right_ok_reg;
                ctl.rd_level = lvl_inc;
                rd_off       = child_right[OFF_W-1:0] & mask_nxt;
                state_next   = ST_DRIGHT;
            end

            ST_DRIGHT:
            begin
                ctl.wr_en    = 1'b1;
                ctl.wr_level = lvl_reg;
                wr_off       = node_reg[OFF_W-1:0] & mask_cur;
                if (key_reg <= pick_key)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    // The smaller child moves up and the sift continues below it.
                    wdata      = pick_key;
                    node_next  = child_left[CNT_W-1:0] + CNT_W'(pick_right);
                    lvl_next   = lvl_inc;
                    state_next = ST_DCHK;
                end
            end

            ST_FIN:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, 7'(cnt_reg),
                                     (cnt_reg != '0) ? 32'(root_reg) : 32'd0,
                                     32'(taken_reg)};
                    m_tuser_next  = {(cnt_reg != '0), status_reg};
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The root copy follows every write to level zero.
    assign root_next = (ctl.wr_en && (ctl.wr_level == '0)) ? wdata : root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            m_tuser_reg  <= m_tuser_next;
        end
    end

    always_ff @(posedge clk)
    begin
        root_reg     <= root_next;
        key_reg      <= key_next;
        left_reg     <= left_next;
        taken_reg    <= taken_next;
        node_reg     <= node_next;
        lvl_reg      <= lvl_next;
        top_lvl_reg  <= top_lvl_next;
        right_ok_reg <= right_ok_next;
        status_reg   <= status_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* hdl/hmq_checker.sv */
// Port-level checks of the heap queue and their binding to the top level.
`timescale 1ns / 1ps
`include "binary_min_heap_queue_top_defines.svh"

module hmq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic [2:0]  m_tuser
);

    logic stalled;
    logic out_empty;
    logic out_full;
    logic failed_op;

    assign stalled   = m_tvalid && !m_tready;
    assign out_empty = m_tvalid && (m_tuser[1:0] == hmq_pkg::STAT_EMPTY);
    assign out_full  = m_tvalid && (m_tuser[1:0] == hmq_pkg::STAT_FULL);
    assign failed_op = out_empty || out_full;

    // A stalled result stays offered and unchanged.
    `HMQ_ASSERT_NEXT(a_out_hold, stalled, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // The minimum is flagged valid exactly when keys remain.
    `HMQ_ASSERT_NOW(a_top_valid, m_tvalid, m_tuser[2] == (m_tdata[70:64] != 7'd0))

    // An empty heap shows no minimum.
    `HMQ_ASSERT_NOW(a_top_zero, m_tvalid && !m_tuser[2], m_tdata[63:32] == 32'd0)

    // A refused operation returns no key, and an empty refusal leaves nothing stored.
    `HMQ_ASSERT_NOW(a_fail_key, failed_op, m_tdata[31:0] == 32'd0)
    `HMQ_ASSERT_NOW(a_empty_cnt, out_empty, m_tdata[70:64] == 7'd0)

endmodule

bind binary_min_heap_queue_top hmq_checker u_hmq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
